// File: rtl/lfg_pkg.sv
// Shared types, constants and helpers for the lagged Fibonacci generator.
package lfg_pkg;

    localparam int TABLE_SIZE = 250;
    localparam int POS_W      = $clog2(TABLE_SIZE);
    localparam int WORD_W     = 32;
    localparam int SEED_W     = 64;
    localparam int MUL_W      = 21;
    localparam int PROD_W     = WORD_W + MUL_W;

    localparam logic [MUL_W-1:0]  LCG_MUL = MUL_W'(1664525);
    localparam logic [SEED_W-1:0] LCG_ADD = SEED_W'(1013904223);

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam pos_t RESET_POS_A = '0;
    localparam pos_t RESET_POS_B = POS_W'(200);
    localparam pos_t RESET_POS_C = POS_W'(103);
    localparam pos_t RESET_POS_D = POS_W'(50);
    localparam pos_t LAST_POS    = POS_W'(TABLE_SIZE - 1);

    localparam logic MODE_RESEED   = 1'b0;
    localparam logic MODE_GENERATE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MLO,
        S_MHI,
        S_ADD,
        S_GC,
        S_GB,
        S_GA,
        S_GW
    } state_t;

    // Step a table position, wrapping from the last entry to zero.
    function automatic pos_t adv_pos(input pos_t p);
        pos_t n;
        if (p == LAST_POS)
        begin
            n = '0;
        end
        else
        begin
            n = p + pos_t'(1);
        end
        return n;
    endfunction

endpackage

// File: rtl/lfg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 250
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lagged_fibonacci_rng.sv
// Top level of the additive lagged Fibonacci random word generator.
// A generate request (mode 1) steps through S_GC, S_GB, S_GA and S_GW: the
// lag table lives in one RAM with a single read port, and the four reads and
// three dependent read-modify-writes pass through it one per cycle unless S_GW
// waits for the result register, sharing a single 32-bit adder. A reseed
// request (mode 0) runs 2 * TABLE_SIZE = 500 steps of the 64-bit congruential
// generator; each step uses one shared 32 x 21 multiplier twice and then
// one 64-bit add, and writes one table entry. Reseeding gives no result and
// leaves the four position counters unchanged. The table must be reseeded
// once before the first generate request. in_stall is high while a request
// is being worked on; a result waits in the output register while out_stall
// is high, and a finished generate holds until that register is free.
module lagged_fibonacci_rng (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [63:0] seed_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_word
);

    lfg_pkg::state_t state_reg, state_next;
    lfg_pkg::pos_t   pos_a_reg, pos_a_next;
    lfg_pkg::pos_t   pos_b_reg, pos_b_next;
    lfg_pkg::pos_t   pos_c_reg, pos_c_next;
    lfg_pkg::pos_t   pos_d_reg, pos_d_next;
    lfg_pkg::pos_t   slot_reg, slot_next;
    logic            pass_reg, pass_next;
    logic            out_valid_reg, out_valid_next;

    logic [lfg_pkg::SEED_W-1:0] seed_reg, seed_next;
    logic [lfg_pkg::PROD_W-1:0] prod_lo_reg, prod_lo_next;
    lfg_pkg::word_t             prod_hi_reg, prod_hi_next;
    lfg_pkg::word_t             acc_reg, acc_next;
    lfg_pkg::word_t             word_reg, word_next;

    logic                       in_accept;
    logic                       out_free;
    logic                       last_step;
    logic [lfg_pkg::WORD_W-1:0] mul_op;
    logic [lfg_pkg::PROD_W-1:0] mul_prod;
    logic [lfg_pkg::SEED_W-1:0] lcg_sum;
    lfg_pkg::word_t             lcg_word;
    lfg_pkg::word_t             add_sum;

    logic            ram_wr_en;
    lfg_pkg::pos_t   ram_wr_addr;
    lfg_pkg::word_t  ram_wr_data;
    lfg_pkg::pos_t   ram_rd_addr;
    lfg_pkg::word_t  ram_rd_data;

    assign in_stall  = (state_reg != lfg_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_step = pass_reg && (slot_reg == lfg_pkg::LAST_POS);

    // Shared multiplier: low seed half first, then the high half.
    assign mul_op   = (state_reg == lfg_pkg::S_MHI) ? seed_reg[63:32] : seed_reg[31:0];
    assign mul_prod = lfg_pkg::PROD_W'(mul_op) * lfg_pkg::PROD_W'(lfg_pkg::LCG_MUL);
    assign lcg_sum  = {prod_hi_reg, 32'b0} + lfg_pkg::SEED_W'(prod_lo_reg) + lfg_pkg::LCG_ADD;

    // Entries 0 and 1 get their final values on the second pass; fold the fixups in here.
    always_comb
    begin
        if (pass_reg && (slot_reg == lfg_pkg::pos_t'(0)))
        begin
            lcg_word = {lcg_sum[30:0], 1'b0};
        end
        else if (pass_reg && (slot_reg == lfg_pkg::pos_t'(1)))
        begin
            lcg_word = lcg_sum[31:0] | 32'd1;
        end
        else
        begin
            lcg_word = lcg_sum[31:0];
        end
    end

    assign add_sum = ram_rd_data + acc_reg;

    lfg_ram #(
        .WIDTH (lfg_pkg::WORD_W),
        .DEPTH (lfg_pkg::TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfg_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (mode == lfg_pkg::MODE_GENERATE) ? lfg_pkg::S_GC
                                                                  : lfg_pkg::S_MLO;
                end
            end
            lfg_pkg::S_MLO: state_next = lfg_pkg::S_MHI;
            lfg_pkg::S_MHI: state_next = lfg_pkg::S_ADD;
            lfg_pkg::S_ADD: state_next = last_step ? lfg_pkg::S_IDLE : lfg_pkg::S_MLO;
            lfg_pkg::S_GC:  state_next = lfg_pkg::S_GB;
            lfg_pkg::S_GB:  state_next = lfg_pkg::S_GA;
            lfg_pkg::S_GA:  state_next = lfg_pkg::S_GW;
            lfg_pkg::S_GW:  state_next = out_free ? lfg_pkg::S_IDLE : lfg_pkg::S_GW;
            default:        state_next = lfg_pkg::S_IDLE;
        endcase
    end

    // Table port control.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_reg;
        ram_wr_data = lcg_word;
        ram_rd_addr = pos_a_reg;
        unique case (state_reg)
            lfg_pkg::S_IDLE:
            begin
                // Fetch t[d] at the advanced position right away.
                ram_rd_addr = lfg_pkg::adv_pos(pos_d_reg);
            end
            lfg_pkg::S_MLO, lfg_pkg::S_MHI:
            begin
                ram_rd_addr = pos_a_reg;
            end
            lfg_pkg::S_ADD:
            begin
                ram_wr_en = 1'b1;
            end
            lfg_pkg::S_GC:
            begin
                ram_rd_addr = pos_c_reg;
            end
            lfg_pkg::S_GB:
            begin
                ram_rd_addr = pos_b_reg;
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_c_reg;
                ram_wr_data = add_sum;
            end
            lfg_pkg::S_GA:
            begin
                ram_rd_addr = pos_a_reg;
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_b_reg;
                ram_wr_data = add_sum;
            end
            lfg_pkg::S_GW:
            begin
                // Hold the read of t[a] until the result register frees up.
                ram_rd_addr = pos_a_reg;
                ram_wr_en   = out_free;
                ram_wr_addr = pos_a_reg;
                ram_wr_data = add_sum;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // Datapath and counter updates.
    always_comb
    begin
        pos_a_next     = pos_a_reg;
        pos_b_next     = pos_b_reg;
        pos_c_next     = pos_c_reg;
        pos_d_next     = pos_d_reg;
        slot_next      = slot_reg;
        pass_next      = pass_reg;
        seed_next      = seed_reg;
        prod_lo_next   = prod_lo_reg;
        prod_hi_next   = prod_hi_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            lfg_pkg::S_IDLE:
            begin
                if (in_accept && (mode == lfg_pkg::MODE_GENERATE))
                begin
                    pos_a_next = lfg_pkg::adv_pos(pos_a_reg);
                    pos_b_next = lfg_pkg::adv_pos(pos_b_reg);
                    pos_c_next = lfg_pkg::adv_pos(pos_c_reg);
                    pos_d_next = lfg_pkg::adv_pos(pos_d_reg);
                end
                else if (in_accept)
                begin
                    seed_next = seed_value;
                    slot_next = '0;
                    pass_next = 1'b0;
                end
            end
            lfg_pkg::S_MLO:
            begin
                prod_lo_next = mul_prod;
            end
            lfg_pkg::S_MHI:
            begin
                prod_hi_next = mul_prod[31:0];
            end
            lfg_pkg::S_ADD:
            begin
                seed_next = lcg_sum;
                slot_next = lfg_pkg::adv_pos(slot_reg);
                if (slot_reg == lfg_pkg::LAST_POS)
                begin
                    pass_next = 1'b1;
                end
            end
            lfg_pkg::S_GC:
            begin
                acc_next = ram_rd_data;
            end
            lfg_pkg::S_GB, lfg_pkg::S_GA:
            begin
                acc_next = add_sum;
            end
            lfg_pkg::S_GW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    word_next      = add_sum;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfg_pkg::S_IDLE;
            pos_a_reg     <= lfg_pkg::RESET_POS_A;
            pos_b_reg     <= lfg_pkg::RESET_POS_B;
            pos_c_reg     <= lfg_pkg::RESET_POS_C;
            pos_d_reg     <= lfg_pkg::RESET_POS_D;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_a_reg     <= pos_a_next;
            pos_b_reg     <= pos_b_next;
            pos_c_reg     <= pos_c_next;
            pos_d_reg     <= pos_d_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        pass_reg    <= pass_next;
        seed_reg    <= seed_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        acc_reg     <= acc_next;
        word_reg    <= word_next;
    end

    assign out_valid   = out_valid_reg;
    assign random_word = word_reg;

endmodule

// File: rtl/lfg_checker.sv
// Port-level checks for the lagged Fibonacci generator, bound to the top level.
module lfg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        mode,
    input logic [63:0] seed_value,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] random_word
);

    logic in_accept;
    assign in_accept = in_valid && !in_stall;

    // A held result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(random_word))
        else $error("held result changed or dropped");

    // A generate request keeps the block busy while its table reads and writes run.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (mode == lfg_pkg::MODE_GENERATE)
        |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
        else $error("generate request finished too early");

    // A reseed request makes no result right after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (mode == lfg_pkg::MODE_RESEED)
        |=> in_stall && !$rose(out_valid))
        else $error("reseed request produced a result");

    // A new result appears only as a request completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && !in_stall)
        else $error("result appeared without a request in progress");

    // A stalled request stays offered with the same payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall
        |=> in_valid && $stable(mode) && $stable(seed_value))
        else $error("stalled request changed or was withdrawn");

endmodule

bind lagged_fibonacci_rng lfg_checker u_lfg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word)
);
